@@ rtl/core/fwpb_pkg.sv @@
`default_nettype none
package fwpb_pkg;
    localparam int FLOW_ENTRIES_DEF = 1024;
    localparam int NUM_TORS_DEF     = 64;
    localparam int NUM_PATHS_DEF    = 8;

    localparam int TIME_W   = 48;
    localparam int WEIGHT_W = 20;
    localparam int FID_W    = 32;
    localparam int TOR_W    = 6;
    localparam int APATH_W  = 3;
    localparam int RND_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 20'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 20'hFFFFF;
    localparam logic [15:0] CUT_Q16   = 16'd43909;
    localparam logic [15:0] SHARE_Q16 = 16'd21627;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_RTT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECENT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATHS    = 3'd4;

    localparam logic [1:0] MODE_UNIFORM  = 2'd0;
    localparam logic [1:0] MODE_WEIGHTED = 2'd1;
    localparam logic [1:0] MODE_NONE     = 2'd2;
    localparam logic [1:0] MODE_RSVD     = 2'd3;

    // one-hot sequencer states
    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_FLRD   = 14'b00000000000010,
        ST_FLCHK  = 14'b00000000000100,
        ST_WSCAN  = 14'b00000000001000,
        ST_WACC   = 14'b00000000010000,
        ST_FLWR   = 14'b00000000100000,
        ST_OUT    = 14'b00000001000000,
        ST_MKRD   = 14'b00000010000000,
        ST_MKCHK  = 14'b00000100000000,
        ST_CNT    = 14'b00001000000000,
        ST_CNTA   = 14'b00010000000000,
        ST_MULT   = 14'b00100000000000,
        ST_DIV    = 14'b01000000000000,
        ST_ADD    = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic        start;
        logic [19:0] dividend;
        logic [3:0]  divisor;
    } div_req_t;
endpackage
`default_nettype wire

@@ rtl/core/fwpb_ram.sv @@
`default_nettype none
module fwpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/fwpb_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module fwpb_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fwpb_pkg::div_req_t req,
    output logic                   done,
    output logic [19:0]            quot
);
    import fwpb_pkg::*;
    logic [19:0] q_reg, q_next;
    logic [4:0]  rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [4:0]  trial;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[3:0], q_reg[19]};
        if (req.start) begin
            q_next = req.dividend;
            rem_next = '0;
            cnt_next = 5'd20;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, req.divisor}) begin
                rem_next = trial - {1'b0, req.divisor};
                q_next = {q_reg[18:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[18:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
    end

    assign done = !busy_reg && !req.start;
    assign quot = q_reg;
endmodule
`default_nettype wire

@@ rtl/core/flowlet_weighted_path_balancer_top.sv @@
`default_nettype none
// Flowlet path balancer. A send item (tuser=0) looks up its flow in a
// direct-mapped table and, on a miss or after the flowlet timeout, picks a
// new path (uniform, weighted by per-destination path weights, or none).
// An ack item (tuser=1) with an ECN mark cuts its path weight to 0.67 and
// shares 0.33 among eligible other paths, at most once per half RTT.
// One item at a time through a small sequencer: a send in weighted mode
// adds a walk over the weight RAM; a marked ack's time is set by the two
// path walks over the weight RAM and a serial divide. After reset a
// clearing pass over all NUM_TORS*NUM_PATHS entries initializes weights
// and mark flags; the flow table holds one valid bit per entry, cleared by
// the same sweep over its FLOW_ENTRIES entries, and the block takes no item
// until the sweep has finished. Configuration writes are
// taken at any time and must be issued only while idle.
module flowlet_weighted_path_balancer_top #(
    parameter int FLOW_ENTRIES = fwpb_pkg::FLOW_ENTRIES_DEF,
    parameter int NUM_TORS     = fwpb_pkg::NUM_TORS_DEF,
    parameter int NUM_PATHS    = fwpb_pkg::NUM_PATHS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata: flow_id[31:0], dest_tor[37:32], ack_path[40:38],
    // ecn_marked[41], now[89:42], random[105:90], zero[111:106]
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tuser,   // cmd
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // m_tdata: path[2:0], status[3], new_decision[4], zero[7:5]
    output logic [7:0]        m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [fwpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fwpb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fwpb_pkg::*;

    localparam int IDX_W  = $clog2(FLOW_ENTRIES);
    localparam int TAG_W  = FID_W - IDX_W;
    localparam int PW     = $clog2(NUM_PATHS);
    localparam int PWC    = $clog2(NUM_PATHS + 1);
    localparam int TW     = $clog2(NUM_TORS);
    localparam int WDEPTH = NUM_TORS * NUM_PATHS;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int FE_W   = 1 + TAG_W + 3 + TIME_W;
    localparam int MK_W   = 1 + TIME_W;
    localparam int CLR_N  = (FLOW_ENTRIES > WDEPTH) ? FLOW_ENTRIES : WDEPTH;
    localparam int CLR_W  = $clog2(CLR_N + 1);

    // configuration
    logic [31:0] timeout_reg, hrtt_reg;
    logic [1:0]  mode_reg;
    logic        recent_reg;
    logic [3:0]  pcnt_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= 32'd40000;
            hrtt_reg <= 32'd40000;
            mode_reg <= MODE_UNIFORM;
            recent_reg <= 1'b0;
            pcnt_reg <= 4'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TIMEOUT:  timeout_reg <= cfg_data;
                REG_HALF_RTT: hrtt_reg <= cfg_data;
                REG_MODE:     mode_reg <= cfg_data[1:0];
                REG_RECENT:   recent_reg <= cfg_data[0];
                REG_PATHS:    pcnt_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective path count
    logic [PWC-1:0] pc;
    always_comb begin
        if (pcnt_reg == 4'd0) pc = PWC'(1);
        else if (32'(pcnt_reg) > 32'(NUM_PATHS)) pc = PWC'(NUM_PATHS);
        else pc = PWC'(pcnt_reg);
    end

    // item registers
    logic                cmd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [TW-1:0]       tor_reg;
    logic [2:0]          ap_reg;
    logic                ecn_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [RND_W-1:0]    rnd_reg;

    state_t st_reg, st_next;
    logic [CLR_W-1:0] clr_reg;
    logic clr_busy;
    assign clr_busy = (clr_reg != CLR_W'(CLR_N));

    // flow table RAM: {valid, tag, path, last_seen}, cleared by sweep
    logic             fl_we;
    logic [IDX_W-1:0] fl_wa;
    logic [FE_W-1:0]  fl_wd, fl_rd;
    fwpb_ram #(.WIDTH(FE_W), .DEPTH(FLOW_ENTRIES)) u_flow (
        .aclk(aclk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
        .raddr(idx_reg), .rdata(fl_rd)
    );

    // weight RAM and mark RAM
    logic             w_we, mk_we;
    logic [WA_W-1:0]  w_wa, w_ra, mk_wa, mk_ra;
    logic [WEIGHT_W-1:0] w_wd, w_rd;
    logic [MK_W-1:0]  mk_wd, mk_rd;
    fwpb_ram #(.WIDTH(WEIGHT_W), .DEPTH(WDEPTH)) u_weight (
        .aclk(aclk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
        .raddr(w_ra), .rdata(w_rd)
    );
    fwpb_ram #(.WIDTH(MK_W), .DEPTH(WDEPTH)) u_mark (
        .aclk(aclk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
        .raddr(mk_ra), .rdata(mk_rd)
    );

    // sequencer working registers
    logic [PW:0]         q_reg;     // path walk counter (one extra bit)
    logic [PW-1:0]       qa_reg;    // address issued last cycle
    logic                qv_reg;    // read in flight
    logic [22:0]         sum_reg;
    logic [PWC-1:0]      cnt_reg;
    logic [WEIGHT_W-1:0] orig_reg, share_reg;
    logic [35:0]         prod_reg;
    logic [2:0]          opath_reg;
    logic                ostat_reg, odec_reg;
    logic [7:0]          m_tdata_reg;
    logic                m_tvalid_reg;

    // shared arithmetic: elapsed time and compare against a limit
    logic [TIME_W-1:0] el_then;
    logic [31:0]       el_lim;
    logic [TIME_W-1:0] el_val;
    logic              el_lt;
    assign el_val = (now_reg >= el_then) ? now_reg - el_then : '0;
    assign el_lt  = el_val < TIME_W'(el_lim);

    div_req_t dreq;
    logic     ddone;
    logic [19:0] dquot;
    fwpb_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quot(dquot));

    logic [WA_W-1:0] base;
    assign base = WA_W'(tor_reg) * WA_W'(NUM_PATHS);

    logic hit, elig, in_acc;
    logic [22:0] target;
    logic [22:0] sum_new;
    logic [20:0] wsum;
    assign in_acc = s_tvalid && s_tready;
    assign target = 23'(rnd_reg) * 23'(pc);
    assign sum_new = sum_reg + 23'(w_rd);
    assign wsum = {1'b0, w_rd} + {1'b0, share_reg};
    assign elig = (qa_reg != ap_reg[PW-1:0] || 3'(qa_reg) != ap_reg) &&
                  (!recent_reg || (mk_rd[MK_W-1] && el_lt));

    always_comb begin
        el_then = fl_rd[TIME_W-1:0];
        el_lim = timeout_reg;
        if (st_reg != ST_FLCHK) begin
            el_then = mk_rd[TIME_W-1:0];
            el_lim = hrtt_reg;
        end
        hit = fl_rd[FE_W-1] && fl_rd[FE_W-2 -: TAG_W] == tag_reg;
    end

    assign s_tready = (st_reg == ST_IDLE) && !clr_busy && !m_tvalid_reg;

    always_comb begin
        st_next = st_reg;
        fl_we = 1'b0; fl_wa = idx_reg; fl_wd = '0;
        w_we = 1'b0; w_wa = base + WA_W'(qa_reg); w_wd = '0;
        w_ra = base + WA_W'(q_reg[PW-1:0]);
        mk_we = 1'b0; mk_wa = base + WA_W'(ap_reg[PW-1:0]);
        mk_wd = {1'b1, now_reg};
        mk_ra = base + WA_W'(q_reg[PW-1:0]);
        dreq.start = 1'b0;
        dreq.dividend = prod_reg[35:16];
        dreq.divisor = 4'(cnt_reg);
        if (clr_busy) begin
            fl_we = (32'(clr_reg) < 32'(FLOW_ENTRIES));
            fl_wa = clr_reg[IDX_W-1:0];
            w_we = (32'(clr_reg) < 32'(WDEPTH));
            w_wa = clr_reg[WA_W-1:0];
            w_wd = WEIGHT_ONE;
            mk_we = w_we;
            mk_wa = clr_reg[WA_W-1:0];
            mk_wd = '0;
        end
        case (st_reg)
            ST_IDLE: if (in_acc) st_next = s_tuser ? ST_MKRD : ST_FLRD;
            ST_FLRD: st_next = ST_FLCHK;
            ST_FLCHK: begin
                if (hit && !(!el_lt)) st_next = ST_FLWR;
                else if (mode_reg == MODE_WEIGHTED) st_next = ST_WSCAN;
                else st_next = ST_FLWR;
            end
            ST_WSCAN: st_next = ST_WACC;
            ST_WACC: begin
                if (target <= sum_new || q_reg == (PW+1)'(pc)) st_next = ST_FLWR;
                else st_next = ST_WSCAN;
            end
            ST_FLWR: begin
                fl_we = 1'b1;
                fl_wd = {1'b1, tag_reg, opath_reg, now_reg};
                st_next = ST_OUT;
            end
            ST_OUT: st_next = ST_IDLE;
            ST_MKRD: begin
                mk_ra = base + WA_W'(ap_reg[PW-1:0]);
                w_ra = base + WA_W'(ap_reg[PW-1:0]);
                if (!ecn_reg || 32'(ap_reg) >= 32'(pc)) st_next = ST_OUT;
                else st_next = ST_MKCHK;
            end
            ST_MKCHK: begin
                if (mk_rd[MK_W-1] && el_lt) begin
                    st_next = ST_OUT;
                end else begin
                    mk_we = 1'b1;
                    st_next = ST_CNT;
                end
            end
            // issue the read of path 0, then count one path per cycle
            ST_CNT: st_next = ST_CNTA;
            ST_CNTA: begin
                if (q_reg == (PW+1)'(pc)) st_next = (cnt_reg + PWC'(elig) == '0) ? ST_OUT : ST_MULT;
                else st_next = ST_CNTA;
            end
            ST_MULT: begin
                dreq.start = 1'b1;
                w_we = 1'b1;
                w_wa = base + WA_W'(ap_reg[PW-1:0]);
                w_wd = WEIGHT_W'((36'(orig_reg) * 36'(CUT_Q16)) >> 16);
                st_next = ST_DIV;
            end
            ST_DIV: if (ddone) st_next = ST_ADD;
            ST_ADD: begin
                if (qv_reg && elig) begin
                    w_we = 1'b1;
                    w_wd = wsum[20] ? WEIGHT_MAX : wsum[19:0];
                end
                if (q_reg == (PW+1)'(pc) && qv_reg) st_next = ST_OUT;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            clr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (clr_busy) clr_reg <= clr_reg + CLR_W'(1);
            if (st_reg == ST_OUT) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
        if (in_acc) begin
            cmd_reg <= s_tuser;
            idx_reg <= s_tdata[IDX_W-1:0];
            tag_reg <= s_tdata[31:IDX_W];
            tor_reg <= TW'(32'(s_tdata[37:32]) % NUM_TORS);
            ap_reg <= s_tdata[40:38];
            ecn_reg <= s_tdata[41];
            now_reg <= s_tdata[89:42];
            rnd_reg <= s_tdata[105:90];
            opath_reg <= '0; ostat_reg <= 1'b0; odec_reg <= 1'b0;
            q_reg <= '0; sum_reg <= '0; cnt_reg <= '0; qv_reg <= 1'b0;
        end
        case (st_reg)
            ST_FLCHK: begin
                if (hit && el_lt) begin
                    opath_reg <= fl_rd[TIME_W +: 3];
                end else begin
                    odec_reg <= 1'b1;
                    if (mode_reg == MODE_UNIFORM)
                        opath_reg <= 3'((23'(rnd_reg) * 23'(pc)) >> 16);
                    else if (mode_reg != MODE_WEIGHTED)
                        ostat_reg <= 1'b1;
                end
            end
            ST_WSCAN: begin
                qa_reg <= q_reg[PW-1:0];
                q_reg <= q_reg + (PW+1)'(1);
            end
            ST_WACC: begin
                sum_reg <= sum_new;
                if (target <= sum_new) opath_reg <= 3'(qa_reg);
                else if (q_reg == (PW+1)'(pc)) ostat_reg <= 1'b1;
            end
            ST_MKCHK: begin
                orig_reg <= w_rd;
                prod_reg <= 36'(w_rd) * 36'(SHARE_Q16);
                q_reg <= '0; qv_reg <= 1'b0;
            end
            ST_CNT, ST_CNTA: begin
                if (st_reg == ST_CNTA) cnt_reg <= cnt_reg + PWC'(elig);
                if (q_reg != (PW+1)'(pc)) begin
                    qa_reg <= q_reg[PW-1:0];
                    q_reg <= q_reg + (PW+1)'(1);
                    qv_reg <= 1'b1;
                end else begin
                    qv_reg <= 1'b0;
                end
            end
            ST_MULT: begin
                q_reg <= '0; qv_reg <= 1'b0;
            end
            ST_DIV: begin
                share_reg <= dquot;
            end
            ST_ADD: begin
                // read q, write it back in the next cycle; paths differ so no hazard
                if (q_reg != (PW+1)'(pc)) begin
                    qa_reg <= q_reg[PW-1:0];
                    q_reg <= q_reg + (PW+1)'(1);
                    qv_reg <= 1'b1;
                end else begin
                    qv_reg <= 1'b0;
                end
            end
            ST_OUT: begin
                m_tdata_reg <= {3'b000, cmd_reg ? 1'b0 : odec_reg,
                                cmd_reg ? 1'b0 : ostat_reg,
                                cmd_reg ? 3'b000 : opath_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule
`default_nettype wire

@@ rtl/core/fwpb_checker.sv @@
`default_nettype none
module fwpb_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [7:0]   m_tdata
);
    // one item at a time: no acceptance while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    // accepted item is not ready again next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready right after accept");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    // padding stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:5] == 3'b000)) else $error("pad bits set");
endmodule

bind flowlet_weighted_path_balancer_top fwpb_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
